FILE: hdl/pfoa_pkg.sv
// ----------------------------------------------------------------------------
// pfoa_pkg
// Shared types and constants for the page frame owner allocator.
// ----------------------------------------------------------------------------
package pfoa_pkg;

    localparam int NUM_FRAMES_DEF = 4096;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam int ADDR_W   = 64;
    localparam int OWNER_W  = 8;
    localparam int STATUS_W = 3;

    localparam logic [OWNER_W-1:0] FREE_MARK = 8'hFF;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_BAD_OWNER    = 3'd1,
        ST_FULL         = 3'd2,
        ST_BAD_ADDR     = 3'd3,
        ST_ALREADY_FREE = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FREE_SUB,
        S_FREE_RD,
        S_FREE_CHK
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    clr_step;
        logic    alloc_commit;
        logic    scan_rd;
        logic    scan_adv;
        logic    ff_from_k;
        logic    free_sub;
        logic    free_rd;
        logic    free_commit;
        logic    res_en;
        logic    res_addr;
        t_status res_st;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic owner_bad;
        logic full;
        logic scan_end;
        logic rd_free;
        logic addr_bad;
    } t_dp_stat;

endpackage

FILE: hdl/pfoa_ctrl.sv
// ----------------------------------------------------------------------------
// pfoa_ctrl
// Sequencer for the allocator: clearing pass, allocate, scan and free steps.
// ----------------------------------------------------------------------------
module pfoa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_cmd,
    input  pfoa_pkg::t_dp_stat i_stat,
    output pfoa_pkg::t_dp_cmd  o_dp_cmd,
    output logic              busy
);
    import pfoa_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd dp_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = (t_cmd'(i_cmd) == CMD_ALLOC) ? S_ALLOC : S_FREE_SUB;
                end
            end
            S_ALLOC: begin
                if (i_stat.owner_bad || i_stat.full) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = i_stat.scan_end ? S_IDLE : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                n_state = i_stat.rd_free ? S_IDLE : S_SCAN_RD;
            end
            S_FREE_SUB: begin
                n_state = S_FREE_RD;
            end
            S_FREE_RD: begin
                n_state = i_stat.addr_bad ? S_IDLE : S_FREE_CHK;
            end
            S_FREE_CHK: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        dp_cmd        = '0;
        dp_cmd.res_st = ST_OK;
        unique case (r_state)
            S_CLEAR: begin
                dp_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                dp_cmd.load = start;
            end
            S_ALLOC: begin
                dp_cmd.res_en = 1'b1;
                priority if (i_stat.owner_bad) begin
                    dp_cmd.res_st = ST_BAD_OWNER;
                end else if (i_stat.full) begin
                    dp_cmd.res_st = ST_FULL;
                end else begin
                    dp_cmd.alloc_commit = 1'b1;
                    dp_cmd.res_addr     = 1'b1;
                end
            end
            S_SCAN_RD: begin
                if (i_stat.scan_end) begin
                    dp_cmd.ff_from_k = 1'b1;
                end else begin
                    dp_cmd.scan_rd = 1'b1;
                end
            end
            S_SCAN_CHK: begin
                if (i_stat.rd_free) begin
                    dp_cmd.ff_from_k = 1'b1;
                end else begin
                    dp_cmd.scan_adv = 1'b1;
                end
            end
            S_FREE_SUB: begin
                dp_cmd.free_sub = 1'b1;
            end
            S_FREE_RD: begin
                if (i_stat.addr_bad) begin
                    dp_cmd.res_en = 1'b1;
                    dp_cmd.res_st = ST_BAD_ADDR;
                end else begin
                    dp_cmd.free_rd = 1'b1;
                end
            end
            S_FREE_CHK: begin
                dp_cmd.res_en = 1'b1;
                if (i_stat.rd_free) begin
                    dp_cmd.res_st = ST_ALREADY_FREE;
                end else begin
                    dp_cmd.free_commit = 1'b1;
                end
            end
            default: begin
                dp_cmd.res_st = ST_OK;
            end
        endcase
    end

    assign o_dp_cmd = dp_cmd;
    assign busy     = (r_state != S_IDLE);

endmodule

FILE: hdl/pfoa_dp.sv
// ----------------------------------------------------------------------------
// pfoa_dp
// Datapath: owner map memory, first-free index, scan pointer, address checks
// and the result register.
// ----------------------------------------------------------------------------
module pfoa_dp #(
    parameter int NUM_FRAMES = pfoa_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_SHIFT = pfoa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pfoa_pkg::t_dp_cmd               i_dp_cmd,
    output pfoa_pkg::t_dp_stat              o_stat,
    input  logic                            i_cfg_we,
    input  logic [pfoa_pkg::ADDR_W-1:0]     i_frame_base,
    input  logic [pfoa_pkg::OWNER_W-1:0]    i_owner_id,
    input  logic [pfoa_pkg::ADDR_W-1:0]     i_page_address,
    output logic                            o_valid,
    output logic [pfoa_pkg::ADDR_W-1:0]     o_frame_address,
    output logic [pfoa_pkg::STATUS_W-1:0]   o_status
);
    import pfoa_pkg::*;

    localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int FF_W  = $clog2(NUM_FRAMES + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_FRAMES - 1);
    localparam logic [FF_W-1:0]   FF_NONE  = FF_W'(NUM_FRAMES);
    localparam logic [ADDR_W-1:0] PAGE_MASK = (ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1);

    logic [OWNER_W-1:0] r_map [NUM_FRAMES];

    logic [ADDR_W-1:0]  r_base;
    logic [OWNER_W-1:0] r_owner;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  r_diff;
    logic               r_below;
    logic               r_unaligned;
    logic [FF_W-1:0]    r_ff;
    logic [FF_W-1:0]    r_k;
    logic [IDX_W-1:0]   r_clr;
    logic [OWNER_W-1:0] r_rd_data;
    logic               r_valid;
    logic [ADDR_W-1:0]  r_frame_address;
    t_status            r_status;

    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [OWNER_W-1:0] wr_data;
    logic               idx_big;
    logic [ADDR_W-1:0]  alloc_addr;

    assign free_idx   = r_diff[PAGE_SHIFT +: IDX_W];
    assign idx_big    = (r_diff >> PAGE_SHIFT) >= ADDR_W'(NUM_FRAMES);
    assign alloc_addr = r_base + (ADDR_W'(r_ff) << PAGE_SHIFT);
    assign rd_addr    = i_dp_cmd.free_rd ? free_idx : r_k[IDX_W-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr;
        wr_data = FREE_MARK;
        priority if (i_dp_cmd.clr_step) begin
            wr_en = 1'b1;
        end else if (i_dp_cmd.alloc_commit) begin
            wr_en   = 1'b1;
            wr_addr = r_ff[IDX_W-1:0];
            wr_data = r_owner;
        end else if (i_dp_cmd.free_commit) begin
            wr_en   = 1'b1;
            wr_addr = free_idx;
        end else begin
            wr_en = 1'b0;
        end
    end

    // owner map
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= wr_data;
        end
        if (i_dp_cmd.scan_rd || i_dp_cmd.free_rd) begin
            r_rd_data <= r_map[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_ff    <= '0;
            r_k     <= '0;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_dp_cmd.res_en;
            if (i_cfg_we) begin
                r_base <= i_frame_base;
            end
            if (i_dp_cmd.clr_step) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (i_dp_cmd.alloc_commit) begin
                r_k <= r_ff + FF_W'(1);
            end
            if (i_dp_cmd.scan_adv) begin
                r_k <= r_k + FF_W'(1);
            end
            if (i_dp_cmd.ff_from_k) begin
                r_ff <= r_k;
            end
            if (i_dp_cmd.free_commit && (FF_W'(free_idx) < r_ff)) begin
                r_ff <= FF_W'(free_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_owner <= i_owner_id;
            r_addr  <= i_page_address;
        end
        if (i_dp_cmd.free_sub) begin
            r_diff      <= r_addr - r_base;
            r_below     <= r_addr < r_base;
            r_unaligned <= (r_addr & PAGE_MASK) != '0;
        end
        if (i_dp_cmd.res_en) begin
            r_frame_address <= i_dp_cmd.res_addr ? alloc_addr : '0;
            r_status        <= i_dp_cmd.res_st;
        end
    end

    always_comb begin
        o_stat.clr_done  = (r_clr == LAST_IDX);
        o_stat.owner_bad = (r_owner == FREE_MARK);
        o_stat.full      = (r_ff == FF_NONE);
        o_stat.scan_end  = (r_k == FF_NONE);
        o_stat.rd_free   = (r_rd_data == FREE_MARK);
        o_stat.addr_bad  = r_below || r_unaligned || idx_big;
    end

    assign o_valid         = r_valid;
    assign o_frame_address = r_frame_address;
    assign o_status        = r_status;

endmodule

FILE: hdl/page_frame_owner_allocator_top.sv
// ----------------------------------------------------------------------------
// page_frame_owner_allocator_top
// First-free page frame allocator with one owner byte per frame.
// ----------------------------------------------------------------------------
// After reset the owner map is swept to free, one frame a cycle, with busy
// high. A command word is taken when start is high and busy low. A free
// subtracts frame_base, reads the owner map and checks the entry, then
// shows its result; a rejected address shows it from the read step. An
// allocate shows its result first; when it succeeds, busy stays high while
// the owner map is searched for the next free frame, a read step and a
// check step per frame probed. Each result is on o_frame_address /
// o_status for one cycle with o_valid high and must be taken then; the
// receiver cannot stall. frame_base is written through the always-ready
// config channel, by the user only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module page_frame_owner_allocator_top #(
    parameter int NUM_FRAMES = pfoa_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_SHIFT = pfoa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cmd,
    input  logic [pfoa_pkg::OWNER_W-1:0]    i_owner_id,
    input  logic [pfoa_pkg::ADDR_W-1:0]     i_page_address,
    output logic                            o_valid,
    output logic [pfoa_pkg::ADDR_W-1:0]     o_frame_address,
    output logic [pfoa_pkg::STATUS_W-1:0]   o_status,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pfoa_pkg::ADDR_W-1:0]     i_frame_base
);
    import pfoa_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    pfoa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .i_stat   (dp_stat),
        .o_dp_cmd (dp_cmd),
        .busy     (busy)
    );

    pfoa_dp #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dp_cmd        (dp_cmd),
        .o_stat          (dp_stat),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_frame_base    (i_frame_base),
        .i_owner_id      (i_owner_id),
        .i_page_address  (i_page_address),
        .o_valid         (o_valid),
        .o_frame_address (o_frame_address),
        .o_status        (o_status)
    );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for page_frame_owner_allocator_top. An owner ledger
// mirrors the owner map, the first-free index and frame_base, predicts the
// word each accepted command returns and checks the words in order. Runs a
// directed set, a partial fill of the map, and random phases under several
// frame_base settings, with random gaps on the command and config sides.
// ----------------------------------------------------------------------------
import pfoa_pkg::*;

typedef struct packed {
    logic [ADDR_W-1:0] addr;
    t_status           st;
} t_frame_word;

class owner_ledger;
    logic [ADDR_W-1:0]  base;
    logic [OWNER_W-1:0] owner_of [NUM_FRAMES_DEF];
    int unsigned        first_free;
    int unsigned        n_used;
    int unsigned        n_bad;
    t_frame_word        due_words [$];

    function new();
        base       = '0;
        first_free = 0;
        n_used     = 0;
        n_bad      = 0;
        foreach (owner_of[i]) owner_of[i] = FREE_MARK;
    endfunction

    function void take_cmd(t_cmd cmd, logic [OWNER_W-1:0] owner, logic [ADDR_W-1:0] pa);
        t_frame_word       w;
        logic [ADDR_W-1:0] off;
        int unsigned       k;
        w.addr = '0;
        w.st   = ST_OK;
        if (cmd == CMD_ALLOC) begin
            if (owner == FREE_MARK) begin
                w.st = ST_BAD_OWNER;
            end else if (first_free >= NUM_FRAMES_DEF) begin
                w.st = ST_FULL;
            end else begin
                w.addr = base + (64'(first_free) << PAGE_SHIFT_DEF);
                owner_of[first_free] = owner;
                n_used++;
                k = first_free;
                while (k < NUM_FRAMES_DEF && owner_of[k] != FREE_MARK) k++;
                first_free = k;
            end
        end else begin
            off = pa - base;
            // alignment is judged on the address itself, not the offset
            if (pa < base || pa[PAGE_SHIFT_DEF-1:0] != '0
                    || (off >> PAGE_SHIFT_DEF) >= 64'(NUM_FRAMES_DEF)) begin
                w.st = ST_BAD_ADDR;
            end else begin
                k = 32'(off >> PAGE_SHIFT_DEF);
                if (owner_of[k] == FREE_MARK) begin
                    w.st = ST_ALREADY_FREE;
                end else begin
                    owner_of[k] = FREE_MARK;
                    n_used--;
                    if (k < first_free) first_free = k;
                end
            end
        end
        due_words.push_back(w);
    endfunction

    function void check_word(logic [ADDR_W-1:0] addr, logic [STATUS_W-1:0] st);
        t_frame_word w;
        if (due_words.size() == 0) begin
            n_bad++;
            if (n_bad <= 10)
                $display("unexpected word: frame_address %h status %0d", addr, st);
            return;
        end
        w = due_words.pop_front();
        if (addr !== w.addr || st !== w.st) begin
            n_bad++;
            if (n_bad <= 10)
                $display("mismatch: frame_address exp %h got %h, status exp %0d got %0d",
                         w.addr, addr, w.st, st);
        end
    endfunction
endclass

module tb_top;

    localparam int          NF      = NUM_FRAMES_DEF;
    localparam int          PS      = PAGE_SHIFT_DEF;
    localparam int unsigned PAGE_SZ = 1 << PS;
    localparam logic [ADDR_W-1:0] PAGE_MASK = 64'(PAGE_SZ - 1);
    localparam longint      N_ITEMS = 1000;
    localparam longint      LIMIT   = 4 * (NF + N_ITEMS * (2 * NF + 26));

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                start          = 1'b0;
    logic                i_cmd          = 1'b0;
    logic [OWNER_W-1:0]  i_owner_id     = '0;
    logic [ADDR_W-1:0]   i_page_address = '0;
    logic                i_cfg_valid    = 1'b0;
    logic [ADDR_W-1:0]   i_frame_base   = '0;
    logic                busy;
    logic                o_valid;
    logic [ADDR_W-1:0]   o_frame_address;
    logic [STATUS_W-1:0] o_status;
    logic                o_cfg_ready;

    owner_ledger ledger;
    longint      cycles     = 0;
    int unsigned quiet_left = 0;
    int unsigned target     = 1;

    page_frame_owner_allocator_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_owner_id      (i_owner_id),
        .i_page_address  (i_page_address),
        .o_valid         (o_valid),
        .o_frame_address (o_frame_address),
        .o_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_frame_base    (i_frame_base)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("page_frame_owner_allocator_top test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) ledger.check_word(o_frame_address, o_status);
    end

    task automatic send(input t_cmd cmd, input logic [OWNER_W-1:0] owner,
                        input logic [ADDR_W-1:0] pa);
        int unsigned gap;
        if (quiet_left > 0) begin
            quiet_left--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 39) == 0) quiet_left = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_cmd          <= cmd;
        i_owner_id     <= owner;
        i_page_address <= pa;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        ledger.take_cmd(cmd, owner, pa);
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (ledger.due_words.size() != 0 || busy);
    endtask

    task automatic write_base(input logic [ADDR_W-1:0] v);
        settle();
        repeat ($urandom_range(0, 5)) @(posedge i_clk);
        i_cfg_valid  <= 1'b1;
        i_frame_base <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ledger.base = v;
    endtask

    function automatic logic [ADDR_W-1:0] slot_addr(input int unsigned idx);
        return ((ledger.base + PAGE_MASK) & ~PAGE_MASK) + (64'(idx) << PS);
    endfunction

    function automatic int unsigned pick_used();
        int unsigned i;
        i = $urandom_range(0, NF - 1);
        while (ledger.owner_of[i] == FREE_MARK) i = (i + 1) % NF;
        return i;
    endfunction

    function automatic logic [OWNER_W-1:0] good_owner();
        return OWNER_W'($urandom_range(0, 254));
    endfunction

    task automatic random_word();
        int unsigned       r;
        logic [ADDR_W-1:0] pa;
        r  = $urandom_range(0, 99);
        pa = {$urandom, $urandom};
        if (r < 77) begin
            if ((r < 42 && ledger.n_used < target) || ledger.n_used == 0)
                send(CMD_ALLOC, good_owner(), pa);
            else
                send(CMD_FREE, OWNER_W'($urandom), slot_addr(pick_used()));
        end else if (r < 82) begin
            send(CMD_ALLOC, FREE_MARK, pa);
        end else if (r < 87) begin
            send(CMD_FREE, OWNER_W'($urandom), slot_addr($urandom_range(0, NF - 1)));
        end else if (r < 95) begin
            case ($urandom_range(0, 3))
                0: send(CMD_FREE, OWNER_W'($urandom), pa);
                1: send(CMD_FREE, OWNER_W'($urandom),
                        slot_addr($urandom_range(0, NF - 1))
                        ^ 64'($urandom_range(1, PAGE_SZ - 1)));
                2: send(CMD_FREE, OWNER_W'($urandom),
                        ledger.base - 64'($urandom_range(1, 4 * PAGE_SZ)));
                default: send(CMD_FREE, OWNER_W'($urandom),
                              slot_addr(NF + $urandom_range(0, 3 * NF)));
            endcase
        end else begin
            send(t_cmd'($urandom_range(0, 1)), OWNER_W'($urandom), pa);
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] nb;
        ledger = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, base zero
        write_base('0);
        send(CMD_ALLOC, 8'h00, '0);
        send(CMD_ALLOC, 8'hFE, '0);
        send(CMD_ALLOC, FREE_MARK, '0);
        send(CMD_ALLOC, 8'h55, '1);
        send(CMD_ALLOC, 8'hAA, '0);
        send(CMD_FREE, FREE_MARK, 64'h1000);
        send(CMD_FREE, 8'h00, 64'h1000);
        send(CMD_FREE, 8'h00, 64'h1001);
        send(CMD_FREE, 8'h00, 64'(NF) << PS);
        send(CMD_FREE, 8'h00, 64'(NF - 1) << PS);
        send(CMD_FREE, 8'h00, '1);
        send(CMD_FREE, 8'h00, 64'h8000_0000_0000_0000);
        send(CMD_ALLOC, 8'h01, '0);
        send(CMD_FREE, 8'h00, 64'h0);
        send(CMD_FREE, 8'h00, 64'h3000);

        // partial fill, then mixed traffic over the filled frames
        write_base({20'h0, $urandom, 12'h0});
        repeat (48) send(CMD_ALLOC, good_owner(), {$urandom, $urandom});
        send(CMD_ALLOC, 8'h7E, '0);
        send(CMD_ALLOC, FREE_MARK, '0);
        send(CMD_FREE, 8'h00, slot_addr(0));
        send(CMD_FREE, 8'h00, slot_addr(0));
        send(CMD_ALLOC, 8'h3C, '0);
        send(CMD_FREE, 8'h00, slot_addr(NF - 1));
        send(CMD_ALLOC, 8'hC3, '0);
        repeat (24) begin
            if ($urandom_range(0, 1) == 1 && ledger.n_used > 0)
                send(CMD_FREE, OWNER_W'($urandom), slot_addr(pick_used()));
            else
                send(CMD_ALLOC, good_owner(), {$urandom, $urandom});
        end
        for (int i = 0; i < NF; i++) begin
            if (ledger.owner_of[i] != FREE_MARK)
                send(CMD_FREE, OWNER_W'($urandom), slot_addr(i));
        end

        // top of the address space: frame addresses wrap
        write_base(64'hFFFF_FFFF_FFFF_F000);
        send(CMD_ALLOC, 8'h11, '0);
        send(CMD_ALLOC, 8'h22, '0);
        send(CMD_FREE, 8'h00, 64'hFFFF_FFFF_FFFF_F000);
        send(CMD_FREE, 8'h00, 64'h0);
        send(CMD_FREE, 8'h00, '1);

        // base off a page boundary
        write_base(64'h1800);
        send(CMD_ALLOC, 8'h33, '0);
        send(CMD_FREE, 8'h00, 64'h1800);
        send(CMD_FREE, 8'h00, 64'h2000);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: nb = '1;
                1: nb = {20'h0, $urandom, 12'h0};
                2: nb = {$urandom, $urandom};
                3: nb = {20'h0, $urandom, 12'($urandom_range(1, PAGE_SZ - 1))};
                4: nb = 64'hFFFF_FFFF_FFFF_F000;
                default: nb = '0;
            endcase
            write_base(nb);
            target = $urandom_range(1, 48);
            repeat (120) random_word();
        end

        settle();
        repeat (2 * NF + 8) @(posedge i_clk);
        if (ledger.n_bad == 0 && ledger.due_words.size() == 0) begin
            $display("page_frame_owner_allocator_top test passed");
        end else begin
            if (ledger.due_words.size() != 0)
                $display("%0d words never arrived", ledger.due_words.size());
            $display("page_frame_owner_allocator_top test failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/pfoa_pkg.sv
hdl/pfoa_ctrl.sv
hdl/pfoa_dp.sv
hdl/page_frame_owner_allocator_top.sv
bench/tb_top.sv
